>>> hw/rtl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants for the countdown timer bank.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int unsigned NumTimersDefault = 4;
  localparam int unsigned CountBitsDefault = 32;
  localparam int unsigned DataBits         = 32;
  localparam int unsigned IrqLines         = 4;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    OFF_LOAD   = 3'd0,
    OFF_COUNT  = 3'd1,
    OFF_CTRL   = 3'd2,
    OFF_EOI    = 3'd3,
    OFF_STATUS = 3'd4,
    OFF_RSVD5  = 3'd5,
    OFF_RSVD6  = 3'd6,
    OFF_RSVD7  = 3'd7
  } off_e;

  localparam int unsigned CtlEnableBit = 0;
  localparam int unsigned CtlUserBit   = 1;
  localparam int unsigned CtlMaskBit   = 2;

  typedef struct packed {
    cmd_e                command;
    logic [1:0]          timer_index;
    off_e                reg_offset;
    logic [DataBits-1:0] write_data;
  } req_t;

endpackage

>>> hw/rtl/cdt_req_if.sv
// ----------------------------------------------------------------------------
// cdt_req_if
// Request channel: tick, register read or register write.
// ----------------------------------------------------------------------------
interface cdt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  timer_index;
  logic [2:0]  reg_offset;
  logic [31:0] write_data;

  modport source (output valid, command, timer_index, reg_offset, write_data, input ready);
  modport sink   (input valid, command, timer_index, reg_offset, write_data, output ready);
endinterface

>>> hw/rtl/cdt_rsp_if.sv
// ----------------------------------------------------------------------------
// cdt_rsp_if
// Response channel: read data and masked interrupt lines.
// ----------------------------------------------------------------------------
interface cdt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [3:0]  irq_lines;

  modport source (output valid, read_data, irq_lines, input ready);
  modport sink   (input valid, read_data, irq_lines, output ready);
endinterface

>>> hw/rtl/cdt_timer.sv
// ----------------------------------------------------------------------------
// cdt_timer
// One down-counting timer: register file, tick update and read mux.
// ----------------------------------------------------------------------------
module cdt_timer #(
  parameter int unsigned CountBits = cdt_pkg::CountBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic                          sel_i,
  input  cdt_pkg::req_t                 req_i,
  output logic [cdt_pkg::DataBits-1:0]  rdata_o,
  output logic                          irq_o
);
  import cdt_pkg::*;

  logic [CountBits-1:0] load_q, load_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 en_q, en_d;
  logic                 user_q, user_d;
  logic                 mask_q, mask_d;
  logic                 flag_q, flag_d;
  logic [CountBits-1:0] reload;
  logic                 is_read, is_write;

  assign is_read  = sel_i && (req_i.command == CMD_READ);
  assign is_write = sel_i && (req_i.command == CMD_WRITE);
  assign reload   = user_q ? load_q : '1;

  always_comb begin
    load_d = load_q;
    cnt_d  = cnt_q;
    en_d   = en_q;
    user_d = user_q;
    mask_d = mask_q;
    flag_d = flag_q;
    if (go_i) begin
      if (req_i.command == CMD_TICK) begin
        if (en_q) begin
          if (cnt_q == '0) begin
            flag_d = 1'b1;
            cnt_d  = reload;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end else if (is_read && (req_i.reg_offset == OFF_EOI)) begin
        flag_d = 1'b0;
      end else if (is_write) begin
        if (req_i.reg_offset == OFF_LOAD) begin
          load_d = req_i.write_data[CountBits-1:0];
        end else if (req_i.reg_offset == OFF_CTRL) begin
          en_d   = req_i.write_data[CtlEnableBit];
          user_d = req_i.write_data[CtlUserBit];
          mask_d = req_i.write_data[CtlMaskBit];
          if (!en_q && en_d) begin
            cnt_d = user_d ? load_q : '1;
          end
        end
      end
    end
  end

  // read mux on pre-update state
  always_comb begin
    rdata_o = '0;
    if (is_read) begin
      unique case (req_i.reg_offset)
        OFF_LOAD:   rdata_o = DataBits'(load_q);
        OFF_COUNT:  rdata_o = DataBits'(cnt_q);
        OFF_CTRL: begin
          rdata_o[CtlEnableBit] = en_q;
          rdata_o[CtlUserBit]   = user_q;
          rdata_o[CtlMaskBit]   = mask_q;
        end
        OFF_STATUS: rdata_o = DataBits'(flag_q && !mask_q);
        default:    rdata_o = '0;
      endcase
    end
  end

  assign irq_o = flag_d && !mask_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      cnt_q  <= '0;
      en_q   <= 1'b0;
      user_q <= 1'b0;
      mask_q <= 1'b0;
      flag_q <= 1'b0;
    end else begin
      load_q <= load_d;
      cnt_q  <= cnt_d;
      en_q   <= en_d;
      user_q <= user_d;
      mask_q <= mask_d;
      flag_q <= flag_d;
    end
  end

endmodule

>>> hw/rtl/countdown_timer_bank_core.sv
// ----------------------------------------------------------------------------
// countdown_timer_bank_core
// Bank of programmable down-counting timers driven by a request stream.
// ----------------------------------------------------------------------------
// a request passes through the request register, then the response register, to response valid
// throughput: one request per cycle while the response is not stalled
// a stalled response blocks only once the request register is also full
// reset: asynchronous, clears all timer registers, flags and both stages
// ----------------------------------------------------------------------------
module countdown_timer_bank_core #(
  parameter int unsigned NumTimers = cdt_pkg::NumTimersDefault,
  parameter int unsigned CountBits = cdt_pkg::CountBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cdt_req_if.sink  req_i,
  cdt_rsp_if.source rsp_o
);
  import cdt_pkg::*;

  req_t                 req_q;
  logic                 req_vld_q;
  logic                 rsp_vld_q;
  logic [DataBits-1:0]  rdata_q, rdata_d;
  logic [IrqLines-1:0]  irq_q, irq_d;
  logic                 advance;
  logic [DataBits-1:0]  tmr_rdata [NumTimers];
  logic [NumTimers-1:0] tmr_irq;

  assign advance     = req_vld_q && (!rsp_vld_q || rsp_o.ready);
  assign req_i.ready = !req_vld_q || advance;

  for (genvar t = 0; t < NumTimers; t++) begin : g_tmr
    localparam logic [2:0] TIdx = 3'(t);
    logic sel;
    assign sel = ({1'b0, req_q.timer_index} == TIdx);

    cdt_timer #(
      .CountBits(CountBits)
    ) u_timer (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .go_i   (advance),
      .sel_i  (sel),
      .req_i  (req_q),
      .rdata_o(tmr_rdata[t]),
      .irq_o  (tmr_irq[t])
    );
  end

  always_comb begin
    rdata_d = '0;
    for (int t = 0; t < NumTimers; t++) begin
      rdata_d = rdata_d | tmr_rdata[t];
    end
  end

  for (genvar t = 0; t < IrqLines; t++) begin : g_irq
    if (t < NumTimers) begin : g_on
      assign irq_d[t] = tmr_irq[t];
    end else begin : g_off
      assign irq_d[t] = 1'b0;
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      req_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q.command     <= cmd_e'(req_i.command);
      req_q.timer_index <= req_i.timer_index;
      req_q.reg_offset  <= off_e'(req_i.reg_offset);
      req_q.write_data  <= req_i.write_data;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (advance) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
    end
  end

  assign rsp_o.valid     = rsp_vld_q;
  assign rsp_o.read_data = rdata_q;
  assign rsp_o.irq_lines = irq_q;

endmodule

>>> tb/sv/tb_countdown_timer_bank_core.sv
// ----------------------------------------------------------------------------
// tb_countdown_timer_bank_core
// Self-checking bench for the countdown timer bank: a short table of directed
// requests, then random program, tick, read and write traffic under several
// valid/ready idle mixes, each response checked against a local bank model or the table.
// ----------------------------------------------------------------------------
module tb_countdown_timer_bank_core;
  import cdt_pkg::*;

  localparam int unsigned NumTimers  = NumTimersDefault;
  localparam int unsigned CntW       = CountBitsDefault;
  localparam int unsigned ItemsPhase = 440;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 10;
  localparam int unsigned CycleLimit = 200000;

  typedef struct {
    logic [DataBits-1:0] rd;
    logic [IrqLines-1:0] irq;
  } resp_t;

  typedef struct {
    cmd_e                cmd;
    logic [1:0]          idx;
    off_e                off;
    logic [DataBits-1:0] wd;
    bit                  typed;
    logic [DataBits-1:0] rd;
    logic [IrqLines-1:0] irq;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  cdt_req_if req_if();
  cdt_rsp_if rsp_if();

  countdown_timer_bank_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // bank model state
  logic [CntW-1:0] ld_val  [NumTimers];
  logic [CntW-1:0] cnt_val [NumTimers];
  logic            en_bit  [NumTimers];
  logic            usr_bit [NumTimers];
  logic            msk_bit [NumTimers];
  logic            irq_flg [NumTimers];

  resp_t    due_resps[$];
  dir_row_t dir_rows[$];
  int       err_cnt    = 0;
  int       idle_pct   = 0;
  int       stall_pct  = 0;
  int       hold_token = 0;

  // typed expectation travels alongside the request
  bit                  drv_typed;
  logic [DataBits-1:0] drv_rd;
  logic [IrqLines-1:0] drv_irq;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [CntW-1:0] reload_val(int t);
    return usr_bit[t] ? ld_val[t] : '1;
  endfunction

  task automatic timer_bank_step(input cmd_e cmd, input logic [1:0] idx, input off_e off,
                                 input logic [DataBits-1:0] wd,
                                 output logic [DataBits-1:0] rd,
                                 output logic [IrqLines-1:0] irq);
    int  t;
    bit  was_on;
    rd  = '0;
    irq = '0;
    t   = idx;
    case (cmd)
      CMD_TICK: begin
        for (int i = 0; i < NumTimers; i++) begin
          if (en_bit[i]) begin
            if (cnt_val[i] == '0) begin
              irq_flg[i] = 1'b1;
              cnt_val[i] = reload_val(i);
            end else begin
              cnt_val[i] = cnt_val[i] - 1'b1;
            end
          end
        end
      end
      CMD_READ: begin
        if (t < NumTimers) begin
          case (off)
            OFF_LOAD:   rd = DataBits'(ld_val[t]);
            OFF_COUNT:  rd = DataBits'(cnt_val[t]);
            OFF_CTRL: begin
              rd[CtlEnableBit] = en_bit[t];
              rd[CtlUserBit]   = usr_bit[t];
              rd[CtlMaskBit]   = msk_bit[t];
            end
            OFF_EOI:    irq_flg[t] = 1'b0;
            OFF_STATUS: rd[0] = irq_flg[t] & ~msk_bit[t];
            default:    rd = '0;
          endcase
        end
      end
      CMD_WRITE: begin
        if (t < NumTimers) begin
          if (off == OFF_LOAD) begin
            ld_val[t] = wd[CntW-1:0];
          end else if (off == OFF_CTRL) begin
            was_on     = en_bit[t];
            en_bit[t]  = wd[CtlEnableBit];
            usr_bit[t] = wd[CtlUserBit];
            msk_bit[t] = wd[CtlMaskBit];
            if (!was_on && en_bit[t]) cnt_val[t] = reload_val(t);
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < NumTimers && i < IrqLines; i++) irq[i] = irq_flg[i] & ~msk_bit[i];
  endtask

  task automatic send_item(input cmd_e cmd, input logic [1:0] idx, input off_e off,
                           input logic [DataBits-1:0] wd, input bit typed = 1'b0,
                           input logic [DataBits-1:0] t_rd = '0,
                           input logic [IrqLines-1:0] t_irq = '0);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.command     <= cmd;
    req_if.timer_index <= idx;
    req_if.reg_offset  <= off;
    req_if.write_data  <= wd;
    drv_typed          <= typed;
    drv_rd             <= t_rd;
    drv_irq            <= t_irq;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic drain_bank();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (due_resps.size() != 0) @(posedge clk_i);
  endtask

  task automatic row(input cmd_e cmd, input logic [1:0] idx, input off_e off,
                     input logic [DataBits-1:0] wd, input bit typed = 1'b0,
                     input logic [DataBits-1:0] rd = '0,
                     input logic [IrqLines-1:0] irq = '0);
    dir_row_t r;
    r.cmd   = cmd;
    r.idx   = idx;
    r.off   = off;
    r.wd    = wd;
    r.typed = typed;
    r.rd    = rd;
    r.irq   = irq;
    dir_rows.push_back(r);
  endtask

  function automatic logic [DataBits-1:0] rand_load();
    return ($urandom_range(99) < 70) ? DataBits'($urandom_range(7)) : $urandom();
  endfunction

  // random traffic: timer programming, tick bursts, reads, writes and idle commands, mostly ticks and reads
  task automatic run_random(input int n_items, input bit hold_mid, input bit pause_mid);
    int                  sent;
    int                  pick;
    logic [1:0]          t;
    off_e                o;
    logic [DataBits-1:0] v;
    bit                  did_mid;
    sent    = 0;
    did_mid = 1'b0;
    while (sent < n_items) begin
      if (!did_mid && sent >= n_items / 2) begin
        did_mid = 1'b1;
        if (hold_mid) hold_token <= hold_token + 1;
        if (pause_mid) drain_bank();
      end
      pick = $urandom_range(99);
      t    = 2'($urandom_range(3));
      if (pick < 10) begin
        if ($urandom_range(1) == 1) begin
          v = $urandom();
          v[CtlEnableBit] = 1'b0;
          send_item(CMD_WRITE, t, OFF_CTRL, v);
          sent++;
        end
        send_item(CMD_WRITE, t, OFF_LOAD, rand_load());
        v = $urandom();
        v[CtlEnableBit] = 1'b1;
        if ($urandom_range(99) < 75) v[CtlUserBit] = 1'b1;
        send_item(CMD_WRITE, t, OFF_CTRL, v);
        sent += 2;
      end else if (pick < 50) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(CMD_TICK, 2'($urandom_range(3)), off_e'($urandom_range(7)), $urandom());
          sent++;
        end
      end else if (pick < 78) begin
        o = off_e'(($urandom_range(9) < 8) ? $urandom_range(4) : $urandom_range(5, 7));
        send_item(CMD_READ, t, o, $urandom());
        sent++;
      end else if (pick < 95) begin
        o = off_e'($urandom_range(7));
        v = (o == OFF_LOAD) ? rand_load() : $urandom();
        send_item(CMD_WRITE, t, o, v);
        sent++;
      end else begin
        send_item(CMD_NONE, t, off_e'($urandom_range(7)), $urandom());
        sent++;
      end
    end
  endtask

  // response sink: random stalls plus an occasional long hold-off
  initial begin : resp_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : scoreboard
    resp_t               exp_r;
    logic [DataBits-1:0] p_rd;
    logic [IrqLines-1:0] p_irq;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
          if (due_resps.size() == 0) begin
            $display("%0t: unexpected response read_data %08h irq_lines %h", $time,
                     rsp_if.read_data, rsp_if.irq_lines);
            err_cnt++;
          end else begin
            exp_r = due_resps.pop_front();
            if (rsp_if.read_data !== exp_r.rd) begin
              $display("%0t: read_data expected %08h actual %08h", $time, exp_r.rd,
                       rsp_if.read_data);
              err_cnt++;
            end
            if (rsp_if.irq_lines !== exp_r.irq) begin
              $display("%0t: irq_lines expected %h actual %h", $time, exp_r.irq,
                       rsp_if.irq_lines);
              err_cnt++;
            end
          end
        end
        if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
          timer_bank_step(cmd_e'(req_if.command), req_if.timer_index,
                          off_e'(req_if.reg_offset), req_if.write_data, p_rd, p_irq);
          exp_r.rd  = drv_typed ? drv_rd : p_rd;
          exp_r.irq = drv_typed ? drv_irq : p_irq;
          due_resps.push_back(exp_r);
        end
      end
    end
  end

  initial begin : watchdog
    int cycle_cnt;
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int idle_mix  [4];
    int stall_mix [4];
    idle_mix  = '{0, 55, 0, 15};
    stall_mix = '{0, 0, 55, 15};
    for (int i = 0; i < NumTimers; i++) begin
      ld_val[i]  = '0;
      cnt_val[i] = '0;
      en_bit[i]  = 1'b0;
      usr_bit[i] = 1'b0;
      msk_bit[i] = 1'b0;
      irq_flg[i] = 1'b0;
    end
    rst_ni             <= 1'b0;
    req_if.valid       <= 1'b0;
    req_if.command     <= CMD_TICK;
    req_if.timer_index <= '0;
    req_if.reg_offset  <= OFF_LOAD;
    req_if.write_data  <= '0;
    drv_typed          <= 1'b0;
    drv_rd             <= '0;
    drv_irq            <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all registers read zero after reset
    row(CMD_READ,  2'd0, OFF_LOAD,   '0, 1'b1, '0, '0);
    row(CMD_READ,  2'd3, OFF_COUNT,  '0, 1'b1, '0, '0);
    row(CMD_READ,  2'd1, OFF_CTRL,   '0, 1'b1, '0, '0);
    row(CMD_READ,  2'd2, OFF_STATUS, '0, 1'b1, '0, '0);
    row(CMD_READ,  2'd2, OFF_RSVD5,  '1, 1'b1, '0, '0);
    row(CMD_NONE,  2'd3, OFF_RSVD7,  '1, 1'b1, '0, '0);
    row(CMD_TICK,  2'd0, OFF_LOAD,   '0, 1'b1, '0, '0);
    // user reload from the widest load value
    row(CMD_WRITE, 2'd0, OFF_LOAD,   32'hFFFF_FFFF, 1'b1, '0, '0);
    row(CMD_READ,  2'd0, OFF_LOAD,   '0, 1'b1, 32'hFFFF_FFFF, '0);
    row(CMD_WRITE, 2'd0, OFF_CTRL,   32'h0000_0003, 1'b1, '0, '0);
    row(CMD_READ,  2'd0, OFF_COUNT,  '0, 1'b1, 32'hFFFF_FFFF, '0);
    // zero load fires on the first tick, upper control bits dropped
    row(CMD_WRITE, 2'd1, OFF_CTRL,   32'hFFFF_FFFB, 1'b1, '0, '0);
    row(CMD_TICK,  2'd0, OFF_LOAD,   '0, 1'b1, '0, 4'h2);
    row(CMD_READ,  2'd1, OFF_CTRL,   '0, 1'b1, 32'h0000_0003, 4'h2);
    row(CMD_READ,  2'd1, OFF_STATUS, '0, 1'b1, 32'h0000_0001, 4'h2);
    row(CMD_READ,  2'd1, OFF_EOI,    '0, 1'b1, '0, '0);
    // free running mode reloads all ones
    row(CMD_WRITE, 2'd2, OFF_CTRL,   32'h0000_0001, 1'b1, '0, '0);
    row(CMD_READ,  2'd2, OFF_COUNT,  '0, 1'b1, 32'hFFFF_FFFF, '0);
    // masked flag, writes to read-only and reserved offsets
    row(CMD_WRITE, 2'd1, OFF_CTRL,   32'h0000_0007);
    row(CMD_TICK,  2'd3, OFF_RSVD6,  '1);
    row(CMD_READ,  2'd1, OFF_STATUS, '0);
    row(CMD_WRITE, 2'd0, OFF_COUNT,  32'h0000_0005);
    row(CMD_WRITE, 2'd0, OFF_STATUS, '1);
    row(CMD_WRITE, 2'd0, OFF_RSVD7,  '1);
    // disabled timer holds its count
    row(CMD_WRITE, 2'd0, OFF_CTRL,   '0);
    row(CMD_TICK,  2'd0, OFF_LOAD,   '0);
    row(CMD_READ,  2'd0, OFF_COUNT,  '0);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].off, dir_rows[i].wd,
                dir_rows[i].typed, dir_rows[i].rd, dir_rows[i].irq);
    end
    drain_bank();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      run_random(ItemsPhase, ph == 0, ph == 1);
      drain_bank();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0 && due_resps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
